>>> rtl/sdi_pkg.sv
// ----------------------------------------------------------------------------
// sdi_pkg
// Shared widths, character codes and limits for the decimal string parser.
// ----------------------------------------------------------------------------
package sdi_pkg;

  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 32;
  localparam int DIGIT_W = 4;
  // magnitude * 10 + digit needs four more bits than the magnitude
  localparam int ACC_W   = VALUE_W + 4;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [VALUE_W-1:0] mag_t;
  typedef logic [ACC_W-1:0]   acc_t;

  // Character codes
  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_LF    = 8'h0A;
  localparam char_t CH_VT    = 8'h0B;
  localparam char_t CH_FF    = 8'h0C;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;

  // Largest magnitudes for positive and negative results
  localparam acc_t POS_LIMIT = acc_t'(64'd2147483647);
  localparam acc_t NEG_LIMIT = acc_t'(64'd2147483648);

  function automatic logic is_space(input char_t c);
    logic r;
    r = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
        (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
    return r;
  endfunction

  function automatic logic is_digit(input char_t c);
    logic r;
    r = (c inside {[CH_ZERO:CH_NINE]});
    return r;
  endfunction

endpackage

>>> rtl/sdi_char_if.sv
// ----------------------------------------------------------------------------
// sdi_char_if
// Character request channel: one byte per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sdi_char_if;

  logic               valid;
  logic               ready;
  sdi_pkg::char_t     char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);

endinterface

>>> rtl/sdi_result_if.sv
// ----------------------------------------------------------------------------
// sdi_result_if
// Result request channel: parsed value and error flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sdi_result_if;

  logic                              valid;
  logic                              ready;
  logic signed [sdi_pkg::VALUE_W-1:0] value;
  logic                              bad_input;

  modport source (output valid, output value, output bad_input, input ready);
  modport sink   (input valid, input value, input bad_input, output ready);

endinterface

>>> rtl/strict_decimal_to_int32.sv
// ----------------------------------------------------------------------------
// strict_decimal_to_int32
// Streaming decimal string to signed 32-bit integer parser.
// ----------------------------------------------------------------------------
// The block takes one character per cycle, unless the input stalls as
// described below, and returns one result for each zero byte. The zero
// byte passes through the input register, then the parse step writes the
// result register, where the result stays valid until it is taken. Leading
// whitespace and one sign are skipped; any later non-digit, or a magnitude
// beyond the signed 32-bit range, sets bad_input and forces value to 0.
// The input register and the result register decouple the two channels, so
// characters keep flowing while a finished result waits; the input stalls
// only when a zero byte reaches the parse step while the result register
// still holds a result nobody has taken.
module strict_decimal_to_int32 (
  input  logic              clk,
  input  logic              rst_n,
  sdi_char_if.sink          in_ch,
  sdi_result_if.source      out_res
);

  // Input register
  logic                 in_vld_r;
  sdi_pkg::char_t       char_r;

  // Parse state
  logic                 in_body_r,  in_body_nxt;
  logic                 neg_r,      neg_nxt;
  logic                 failed_r,   failed_nxt;
  sdi_pkg::mag_t        mag_r,      mag_nxt;

  // Result register
  logic                 out_vld_r;
  sdi_pkg::mag_t        out_value_r, out_value_nxt;
  logic                 out_bad_r;

  logic                 is_term;
  logic                 advance;
  logic                 in_ready;
  logic                 take;
  logic                 lead;
  logic                 skip_ws;
  logic                 skip_sign;
  logic                 over;
  logic [sdi_pkg::DIGIT_W-1:0] dval;
  sdi_pkg::acc_t        acc;
  sdi_pkg::acc_t        limit;

  // Handshake: the parse step moves when it has a char and, for a
  // terminator, the result register is free or being emptied
  assign is_term  = (char_r == sdi_pkg::CH_NUL);
  assign advance  = in_vld_r && (!is_term || !out_vld_r || out_res.ready);
  assign in_ready = !in_vld_r || advance;
  assign in_ch.ready = in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      char_r <= in_ch.char_in;
    end
  end

  // Times-ten accumulate and range check
  assign dval  = sdi_pkg::DIGIT_W'(char_r - sdi_pkg::CH_ZERO);
  assign acc   = (sdi_pkg::acc_t'(mag_r) << 3) + (sdi_pkg::acc_t'(mag_r) << 1)
               + sdi_pkg::acc_t'(dval);
  assign limit = neg_r ? sdi_pkg::NEG_LIMIT : sdi_pkg::POS_LIMIT;
  assign over  = (acc > limit);

  // Character classification
  assign take      = !failed_r && !is_term;
  assign lead      = take && !in_body_r;
  assign skip_ws   = lead && sdi_pkg::is_space(char_r);
  assign skip_sign = lead && !skip_ws &&
                     ((char_r == sdi_pkg::CH_MINUS) || (char_r == sdi_pkg::CH_PLUS));

  // Next parse state
  always_comb begin
    in_body_nxt = in_body_r;
    neg_nxt     = neg_r;
    failed_nxt  = failed_r;
    mag_nxt     = mag_r;
    if (is_term) begin
      in_body_nxt = 1'b0;
      neg_nxt     = 1'b0;
      failed_nxt  = 1'b0;
      mag_nxt     = '0;
    end else if (take) begin
      if (!skip_ws) begin
        in_body_nxt = 1'b1;
      end
      if (skip_sign) begin
        neg_nxt = (char_r == sdi_pkg::CH_MINUS);
      end else if (!skip_ws) begin
        if (!sdi_pkg::is_digit(char_r) || over) begin
          failed_nxt = 1'b1;
        end else begin
          mag_nxt = acc[sdi_pkg::VALUE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r <= 1'b0;
      neg_r     <= 1'b0;
      failed_r  <= 1'b0;
      mag_r     <= '0;
    end else if (advance) begin
      in_body_r <= in_body_nxt;
      neg_r     <= neg_nxt;
      failed_r  <= failed_nxt;
      mag_r     <= mag_nxt;
    end
  end

  // Result value: the magnitude, negated in two's complement after a minus sign, 0 on error
  always_comb begin
    if (failed_r) begin
      out_value_nxt = '0;
    end else if (neg_r) begin
      out_value_nxt = '0 - mag_r;
    end else begin
      out_value_nxt = mag_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && is_term) begin
      out_vld_r <= 1'b1;
    end else if (out_res.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_term) begin
      out_value_r <= out_value_nxt;
      out_bad_r   <= failed_r;
    end
  end

  assign out_res.valid     = out_vld_r;
  assign out_res.value     = $signed(out_value_r);
  assign out_res.bad_input = out_bad_r;

  // Assertions
  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_term) |=> (!in_body_r && !neg_r && !failed_r && (mag_r == '0)))
    else $error("state not cleared after terminator");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_bad_r) |-> (out_value_r == '0))
    else $error("error result carries nonzero value");

  a_failed_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (failed_r && !(advance && is_term)) |=> (failed_r && $stable(mag_r)))
    else $error("state changed after error");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_vld_r && is_term && out_vld_r && !out_res.ready))
    else $error("input stalled without a blocked terminator");

  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!neg_r && in_body_r) |-> !mag_r[sdi_pkg::VALUE_W-1])
    else $error("positive magnitude past range");

endmodule
